[design/nearest_waypoint_ahead_search_macros.svh]
// assertion macros for the nearest waypoint ahead search
`ifndef NEAREST_WAYPOINT_AHEAD_SEARCH_MACROS_SVH
`define NEAREST_WAYPOINT_AHEAD_SEARCH_MACROS_SVH
`ifndef SYNTH
`define NWA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define NWA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define NWA_ASSERT_IMP(label, clk, rst, a, c)
`define NWA_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[design/nwa_pkg.sv]
// ----------------------------------------------------------------------------
// nwa_pkg
// shared types and constants of the nearest waypoint ahead search
// ----------------------------------------------------------------------------
`default_nettype none
package nwa_pkg;
  localparam int MaxWaypoints = 1024;
  localparam int IdxW = $clog2(MaxWaypoints);
  localparam int CntW = IdxW + 1;
  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam int PosW = 31;
  localparam int DW = PosW + 1;
  localparam int CW = DW + 3;
  localparam int AngW = 16;
  localparam int ZW = 18;
  localparam int SqW = 2 * DW;
  localparam int DistW = SqW + 1;
  localparam logic [DistW-1:0] FarLimitSq = DistW'(64'd10485760000000000);
  localparam logic signed [ZW-1:0] AngPi = ZW'(25736);
  localparam logic signed [ZW-1:0] AngHalfPi = ZW'(12868);
  localparam logic signed [ZW-1:0] AngTwoPi = ZW'(51472);

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  typedef struct packed {
    logic append;
    logic scan_start;
    logic scan_step;
    logic cordic_load;
    logic cordic_step;
    logic clear;
  } ctrl_t;

  typedef struct packed {
    logic scan_last;
    logic cordic_last;
    logic empty;
    logic full;
  } stat_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = ZW'(6434);
      1: r = ZW'(3798);
      2: r = ZW'(2007);
      3: r = ZW'(1019);
      4: r = ZW'(511);
      5: r = ZW'(256);
      6: r = ZW'(128);
      7: r = ZW'(64);
      8: r = ZW'(32);
      9: r = ZW'(16);
      10: r = ZW'(8);
      11: r = ZW'(4);
      12: r = ZW'(2);
      13: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[design/nwa_datapath.sv]
// ----------------------------------------------------------------------------
// nwa_datapath
// waypoint memories, distance scan pipeline, cordic and result logic
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_waypoint_ahead_search_macros.svh"
module nwa_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire nwa_pkg::ctrl_t ctrl,
  output nwa_pkg::stat_t stat,
  input  wire logic signed [30:0] pos_x,
  input  wire logic signed [30:0] pos_y,
  input  wire logic signed [15:0] heading_angle,
  output logic [9:0] closest_index,
  output logic [10:0] next_index,
  output logic signed [10:0] last_index,
  output logic behind
);
  import nwa_pkg::*;

  logic signed [PosW-1:0] mem_x [MaxWaypoints];
  logic signed [PosW-1:0] mem_y [MaxWaypoints];
  logic [CntW-1:0] count;
  logic signed [PosW-1:0] qx, qy;
  logic signed [AngW-1:0] yaw;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] issued;
  logic signed [PosW-1:0] rd_x, rd_y;
  logic v1, v2, v3;
  logic [IdxW-1:0] a1, a2, a3;
  logic signed [DW-1:0] dx2, dy2;
  logic [SqW-1:0] sqx, sqy;
  logic [DistW-1:0] best_d;
  logic [IdxW-1:0] best;
  logic signed [DW-1:0] best_dx, best_dy;
  logic signed [DW-1:0] bdx1, bdy1;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [StepW-1:0] step;
  logic zero_vec;
  logic [DistW-1:0] sq_dist;
  logic signed [ZW-1:0] dd, da;
  logic bh;

  always_ff @(posedge clk) begin
    if (ctrl.append && !stat.full) begin
      mem_x[count[IdxW-1:0]] <= pos_x;
      mem_y[count[IdxW-1:0]] <= pos_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  assign stat.empty = (count == '0);
  assign stat.full = (count == CntW'(MaxWaypoints));
  assign stat.scan_last = (issued == count) && !v1 && !v2 && !v3;
  assign stat.cordic_last = (step == StepW'(CordicSteps));
  assign sq_dist = DistW'(sqx) + DistW'(sqy);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      issued <= '0;
      rd_addr <= '0;
    end else begin
      if (ctrl.clear) count <= '0;
      else if (ctrl.append && !stat.full) count <= count + 1'b1;
      v1 <= ctrl.scan_step && (issued != count);
      v2 <= v1;
      v3 <= v2;
      if (ctrl.scan_start) begin
        issued <= '0;
        rd_addr <= '0;
      end else if (ctrl.scan_step && issued != count) begin
        issued <= issued + 1'b1;
        rd_addr <= rd_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a1 <= rd_addr;
    a2 <= a1;
    a3 <= a2;
    dx2 <= DW'(rd_x) - DW'(qx);
    dy2 <= DW'(rd_y) - DW'(qy);
    bdx1 <= dx2;
    bdy1 <= dy2;
    sqx <= SqW'(dx2 * dx2);
    sqy <= SqW'(dy2 * dy2);
    if (ctrl.scan_start) begin
      qx <= pos_x;
      qy <= pos_y;
      yaw <= heading_angle;
      best_d <= FarLimitSq;
      best <= '0;
      best_dx <= '0;
      best_dy <= '0;
    end else if (v3 && sq_dist < best_d) begin
      best_d <= sq_dist;
      best <= a3;
      best_dx <= bdx1;
      best_dy <= bdy1;
    end
  end

  // first best may be index 0 with no update; fetch its deltas then
  logic first_hit;
  always_ff @(posedge clk) begin
    if (ctrl.scan_start) first_hit <= 1'b0;
    else if (v3 && a3 == '0) first_hit <= 1'b1;
  end
  logic signed [DW-1:0] d0x, d0y;
  always_ff @(posedge clk) begin
    if (v3 && a3 == '0) begin
      d0x <= bdx1;
      d0y <= bdy1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cordic_load) begin
      logic signed [DW-1:0] ux, uy;
      ux = (best_d == FarLimitSq && first_hit) ? d0x : best_dx;
      uy = (best_d == FarLimitSq && first_hit) ? d0y : best_dy;
      step <= '0;
      zero_vec <= (ux == '0) && (uy == '0);
      if (ux < 0) begin
        cx <= -CW'(ux);
        cy <= -CW'(uy);
        cz <= (uy >= 0) ? AngPi : -AngPi;
      end else begin
        cx <= CW'(ux);
        cy <= CW'(uy);
        cz <= '0;
      end
    end else if (ctrl.cordic_step && !stat.cordic_last) begin
      step <= step + 1'b1;
      if (cy > 0) begin
        cx <= cx + (cy >>> step);
        cy <= cy - (cx >>> step);
        cz <= cz + atan_entry(step);
      end else begin
        cx <= cx - (cy >>> step);
        cy <= cy + (cx >>> step);
        cz <= cz - atan_entry(step);
      end
    end
  end

  always_comb begin
    dd = ZW'(yaw) - (zero_vec ? ZW'(0) : cz);
    if (dd < 0) dd = -dd;
    da = AngTwoPi - dd;
    if (da < dd) dd = da;
    bh = dd > AngHalfPi;
  end

  always_comb begin
    logic [CntW-1:0] nx;
    nx = CntW'(best) + CntW'(bh);
    closest_index = best;
    next_index = nx;
    last_index = nx - 1'b1;
    behind = bh;
  end

  `NWA_ASSERT_NEXT(a_count_inc, clk, rst, ctrl.append && !stat.full && !ctrl.clear, count == $past(count) + 1'b1)
  `NWA_ASSERT_NEXT(a_clear, clk, rst, ctrl.clear, count == '0)
  `NWA_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CntW'(MaxWaypoints))
endmodule
`default_nettype wire

[design/nwa_controller.sv]
// ----------------------------------------------------------------------------
// nwa_controller
// command sequencer for table updates and queries
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_waypoint_ahead_search_macros.svh"
module nwa_controller (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [1:0] operation,
  output logic busy,
  output logic done,
  output logic table_empty,
  output logic table_full,
  output logic use_dp,
  output nwa_pkg::ctrl_t ctrl,
  input  wire nwa_pkg::stat_t stat
);
  import nwa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CORDIC, S_DONE} state_t;
  state_t state;
  logic go;

  assign go = start && !busy;
  assign busy = (state != S_IDLE);

  always_comb begin
    ctrl = '0;
    ctrl.clear = go && operation == OpClear;
    ctrl.append = go && operation == OpAppend;
    ctrl.scan_start = go && operation == OpQuery && !stat.empty;
    ctrl.scan_step = (state == S_SCAN);
    ctrl.cordic_load = (state == S_SCAN) && stat.scan_last;
    ctrl.cordic_step = (state == S_CORDIC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      table_empty <= 1'b0;
      table_full <= 1'b0;
      use_dp <= 1'b0;
    end else begin
      done <= 1'b0;
      table_empty <= 1'b0;
      table_full <= 1'b0;
      use_dp <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go && operation == OpAppend && stat.full) begin
            done <= 1'b1;
            table_full <= 1'b1;
          end else if (go && operation == OpQuery && stat.empty) begin
            done <= 1'b1;
            table_empty <= 1'b1;
          end else if (ctrl.scan_start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: if (stat.scan_last) state <= S_CORDIC;
        S_CORDIC: if (stat.cordic_last) state <= S_DONE;
        S_DONE: begin
          done <= 1'b1;
          use_dp <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NWA_ASSERT_IMP(a_done_idle, clk, rst, done, state == S_IDLE)
  `NWA_ASSERT_IMP(a_flags_excl, clk, rst, 1'b1, !(table_empty && table_full))
  `NWA_ASSERT_IMP(a_flag_done, clk, rst, table_empty || table_full || use_dp, done)
endmodule
`default_nettype wire

[design/nearest_waypoint_ahead_search.sv]
// ----------------------------------------------------------------------------
// nearest_waypoint_ahead_search
// waypoint table with nearest-waypoint query and heading check
// ----------------------------------------------------------------------------
// channel   | ports                                   | transfer
// command   | operation pos_x pos_y heading_angle     | start && !busy
// result    | closest/next/last_index behind flags    | done, one cycle
// clear, append: no result unless append hits a full table
// query: the result follows the one-read-per-cycle memory scan
// and the 16 cordic iterations; empty or full results come the next cycle
// reset clears the waypoint count; stored coordinates are not cleared
// results cannot be stalled
`default_nettype none
module nearest_waypoint_ahead_search (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] operation,
  input  wire logic signed [30:0] pos_x,
  input  wire logic signed [30:0] pos_y,
  input  wire logic signed [15:0] heading_angle,
  output logic done,
  output logic [9:0] closest_index,
  output logic [10:0] next_index,
  output logic signed [10:0] last_index,
  output logic behind,
  output logic table_empty,
  output logic table_full
);
  import nwa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic use_dp;
  logic [9:0] ci;
  logic [10:0] ni;
  logic signed [10:0] li;
  logic bh;

  nwa_controller u_ctrl (
    .clk, .rst, .start, .operation, .busy, .done, .table_empty, .table_full,
    .use_dp, .ctrl, .stat
  );

  nwa_datapath u_dp (
    .clk, .rst, .ctrl, .stat, .pos_x, .pos_y, .heading_angle,
    .closest_index(ci), .next_index(ni), .last_index(li), .behind(bh)
  );

  assign closest_index = use_dp ? ci : '0;
  assign next_index = use_dp ? ni : '0;
  assign last_index = use_dp ? li : (table_empty ? 11'sh7FF : '0);
  assign behind = use_dp ? bh : 1'b0;
endmodule
`default_nettype wire

[dv/nearest_waypoint_ahead_search_tb.sv]
// ----------------------------------------------------------------------------
// nearest_waypoint_ahead_search_tb
// self-checking bench for the waypoint table and nearest-ahead query: a short
// directed table, then random tracks of waypoints with queries near them and
// sender gaps of several densities; every result is compared field by field
// against an in-bench predictor
// ----------------------------------------------------------------------------
module nearest_waypoint_ahead_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nwa_pkg::*;

  localparam logic [1:0] OpIgnored = 2'd3;
  localparam longint PosMin = -(64'sd1 <<< 30);
  localparam longint PosMax = (64'sd1 <<< 30) - 1;
  localparam int YawPi = 25736;
  localparam int YawHalfPi = 12868;
  localparam int YawTwoPi = 51472;
  localparam logic [63:0] FarSq = 64'd10485760000000000;

  typedef struct packed {
    logic [9:0] closest;
    logic [10:0] next;
    logic [10:0] last;
    logic behind;
    logic empty;
    logic full;
  } search_result_t;

  typedef struct {
    logic [1:0] op;
    longint x;
    longint y;
    int yaw;
    bit typed;
    search_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] operation = OpClear;
  logic signed [30:0] pos_x = '0;
  logic signed [30:0] pos_y = '0;
  logic signed [15:0] heading_angle = '0;
  logic busy, done, behind, table_empty, table_full;
  logic [9:0] closest_index;
  logic [10:0] next_index;
  logic signed [10:0] last_index;

  nearest_waypoint_ahead_search dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  longint wp_x [MaxWaypoints];
  longint wp_y [MaxWaypoints];
  int wp_count;
  search_result_t pending_results [$];
  int fail_count = 0;
  int idle_pct = 0;
  int items_sent = 0;

  function automatic int cordic_bearing(longint yv, longint xv);
    int z;
    longint xs, ys;
    z = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      z = (yv >= 0) ? YawPi : -YawPi;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv > 0) begin
        xv = xv + ys;
        yv = yv - xs;
        z = z + int'(atan_entry(StepW'(i)));
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        z = z - int'(atan_entry(StepW'(i)));
      end
    end
    return z;
  endfunction

  task automatic predict_search(input logic [1:0] op, input longint px, input longint py,
                                input int yaw, output bit has_res, output search_result_t r);
    logic [63:0] best_d, sq_dist;
    longint dx, dy;
    int best, d, nxt;
    bit bh;
    has_res = 0;
    r = '0;
    best = 0;
    best_d = FarSq;
    case (op)
      OpClear: wp_count = 0;
      OpAppend: begin
        if (wp_count < MaxWaypoints) begin
          wp_x[wp_count] = px;
          wp_y[wp_count] = py;
          wp_count++;
        end else begin
          has_res = 1;
          r.full = 1'b1;
        end
      end
      OpQuery: begin
        has_res = 1;
        if (wp_count == 0) begin
          r.last = 11'h7FF;
          r.empty = 1'b1;
        end else begin
          for (int i = 0; i < wp_count; i++) begin
            dx = wp_x[i] - px;
            dy = wp_y[i] - py;
            sq_dist = 64'(dx * dx) + 64'(dy * dy);
            if (sq_dist < best_d) begin
              best_d = sq_dist;
              best = i;
            end
          end
          d = yaw - cordic_bearing(wp_y[best] - py, wp_x[best] - px);
          if (d < 0) d = -d;
          if (YawTwoPi - d < d) d = YawTwoPi - d;
          bh = d > YawHalfPi;
          nxt = best + int'(bh);
          r.closest = 10'(best);
          r.next = 11'(nxt);
          r.last = 11'(nxt - 1);
          r.behind = bh;
        end
      end
      default: ;
    endcase
  endtask

  task automatic issue_command(input logic [1:0] op, input longint px, input longint py,
                               input int yaw, input bit typed = 0,
                               input search_result_t typed_res = '0);
    bit has_res;
    search_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    operation = op;
    pos_x = 31'(px);
    pos_y = 31'(py);
    heading_angle = 16'(yaw);
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_search(op, px, py, yaw, has_res, r);
    if (has_res) pending_results.push_back(typed ? typed_res : r);
    if (op != OpIgnored) items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic longint clamp_pos(longint v);
    if (v < PosMin) return PosMin;
    if (v > PosMax) return PosMax;
    return v;
  endfunction

  function automatic longint rand_pos();
    return longint'($signed(31'($urandom)));
  endfunction

  function automatic longint near_pos(longint c);
    int k;
    k = $urandom_range(20);
    return clamp_pos(c + longint'($urandom_range(0, 2 ** (k + 1))) - (64'sd1 <<< k));
  endfunction

  function automatic int rand_yaw();
    if ($urandom_range(99) < 85) return $urandom_range(YawTwoPi) - YawPi;
    return int'($signed(16'($urandom)));
  endfunction

  always @(posedge clk) begin
    search_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (closest_index !== e.closest) begin
          $error("closest_index exp %0d got %0d", e.closest, closest_index); fail_count++;
        end
        if (next_index !== e.next) begin
          $error("next_index exp %0d got %0d", e.next, next_index); fail_count++;
        end
        if (last_index !== e.last) begin
          $error("last_index exp %0h got %0h", e.last, last_index); fail_count++;
        end
        if (behind !== e.behind) begin
          $error("behind exp %0b got %0b", e.behind, behind); fail_count++;
        end
        if (table_empty !== e.empty) begin
          $error("table_empty exp %0b got %0b", e.empty, table_empty); fail_count++;
        end
        if (table_full !== e.full) begin
          $error("table_full exp %0b got %0b", e.full, table_full); fail_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    search_result_t empty_res;
    longint cx, cy, sx, sy, tx, ty;
    int n, idle_sel [4];
    empty_res = '0; empty_res.last = 11'h7FF; empty_res.empty = 1'b1;
    idle_sel = '{0, 86, 0, 28};
    wp_count = 0;

    rows = '{
      '{OpQuery, 0, 0, 0, 1, empty_res},
      '{OpIgnored, PosMax, PosMin, 32767, 0, '0},
      '{OpQuery, PosMax, PosMax, YawPi, 1, empty_res},
      '{OpAppend, PosMax, PosMax, 0, 0, '0},
      '{OpAppend, PosMin, PosMin, 0, 0, '0},
      '{OpQuery, PosMin, PosMin, 0, 0, '0},
      '{OpQuery, PosMax - 5, PosMax - 3, YawPi, 0, '0},
      '{OpQuery, PosMax - 5, PosMax - 3, -YawPi, 0, '0},
      '{OpQuery, 0, 0, -32768, 0, '0},
      '{OpQuery, 0, 0, 32767, 0, '0},
      '{OpAppend, 1000, -2000, 0, 0, '0},
      '{OpQuery, 1000, -2000, YawHalfPi + 1, 0, '0},
      '{OpQuery, 0, -2000, YawPi, 0, '0},
      '{OpQuery, 0, -2000, 0, 0, '0},
      '{OpQuery, 2000, -2000, 0, 0, '0},
      '{OpClear, 0, 0, 0, 0, '0},
      '{OpQuery, 5, 5, 0, 1, empty_res},
      '{OpAppend, 200_000_000, 0, 0, 0, '0},
      '{OpAppend, 0, -300_000_000, 0, 0, '0},
      '{OpQuery, 0, 0, YawHalfPi, 0, '0},
      '{OpAppend, 102_400_000, 0, 0, 0, '0},
      '{OpAppend, 102_399_999, 0, 0, 0, '0},
      '{OpQuery, 0, 0, -YawHalfPi, 0, '0},
      '{OpQuery, 0, 0, 0, 0, '0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i])
      issue_command(rows[i].op, rows[i].x, rows[i].y, rows[i].yaw, rows[i].typed, rows[i].res);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_sel[ph];
      while (items_sent < 30 + (ph + 1) * 135) begin
        cx = rand_pos();
        cy = rand_pos();
        if ($urandom_range(99) < 80) issue_command(OpClear, rand_pos(), rand_pos(), rand_yaw());
        sx = longint'($urandom_range(0, 8192)) - 4096;
        sy = longint'($urandom_range(0, 8192)) - 4096;
        n = $urandom_range(1, 14);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(99) < 15) begin
            tx = rand_pos(); ty = rand_pos();
          end else begin
            tx = clamp_pos(cx + k * sx + longint'($urandom_range(0, 64)) - 32);
            ty = clamp_pos(cy + k * sy + longint'($urandom_range(0, 64)) - 32);
          end
          issue_command(OpAppend, tx, ty, rand_yaw());
        end
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(99) < 10) begin
            tx = rand_pos(); ty = rand_pos();
          end else begin
            tx = near_pos(clamp_pos(cx + $urandom_range(0, 14) * sx));
            ty = near_pos(clamp_pos(cy + $urandom_range(0, 14) * sy));
          end
          issue_command(OpQuery, tx, ty, rand_yaw());
        end
        if ($urandom_range(99) < 5)
          issue_command(OpIgnored, rand_pos(), rand_pos(), int'($signed(16'($urandom))));
        if ($urandom_range(99) < 10) drain_results();
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
